FILE: sv/gregorian_date_offset_weekday_macros.svh
// Assertion macros of the date shifter top level.
`ifndef GREGORIAN_DATE_OFFSET_WEEKDAY_MACROS_SVH
`define GREGORIAN_DATE_OFFSET_WEEKDAY_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GDOW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GDOW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gdow_pkg.sv
// Types, constants and calendar functions of the date shifter.
package gdow_pkg;

  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;
  localparam logic [6:0]  CENT_LAST  = 7'd99;
  localparam logic [13:0] YEAR_CENT  = 14'd100;
  localparam logic [13:0] WEEK_DAYS  = 14'd7;

  // Reciprocals for exact quotients of 14-bit values
  localparam int RECIP100 = 5243;
  localparam int SHIFT100 = 19;
  localparam int RECIP7   = 18725;
  localparam int SHIFT7   = 17;
  localparam int PROD_W   = 29;

  typedef struct packed {
    logic [13:0]        year_in;
    logic [3:0]         month_in;
    logic [4:0]         day_in;
    logic signed [15:0] day_offset;
    logic [13:0]        other_year;
    logic [3:0]         other_month;
    logic [4:0]         other_day;
  } gdow_req_t;

  typedef struct packed {
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [2:0]  weekday;
    logic [1:0]  order;
    logic        out_of_range;
  } gdow_res_t;

  typedef enum logic [1:0] {
    ORD_EARLIER = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_LATER   = 2'd2
  } gdow_order_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SAT, ST_DIV, ST_SPLIT, ST_CLAMP, ST_INITK, ST_WALKF, ST_WALKB,
    ST_FINB, ST_WKINIT, ST_WKCENT, ST_WKCENT4, ST_WKMON, ST_WKDAY, ST_MODMUL,
    ST_MODSUB, ST_DONE
  } gdow_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SAT, OP_DIV, OP_SPLIT, OP_CLAMP, OP_INITK, OP_WALKF,
    OP_WALKB, OP_FINB, OP_WKINIT, OP_WKCENT, OP_WKCENT4, OP_WKMON, OP_WKDAY,
    OP_MODMUL, OP_MODSUB
  } gdow_op_e;

  typedef struct packed {
    gdow_op_e op;
    logic     done;
  } gdow_ctrl_t;

  typedef struct packed {
    logic fwd;
    logic walk_cont;
    logic walk_flag;
    logic mon_cont;
  } gdow_stat_t;

  typedef struct packed {
    logic signed [17:0] a;
    logic signed [17:0] b;
    logic signed [17:0] cmp;
    logic               sub;
  } gdow_alu_req_t;

  typedef struct packed {
    logic signed [17:0] res;
    logic               pos;
    logic               ge;
  } gdow_alu_rsp_t;

  // Year split as century and year of century, low two bits of the year given
  function automatic logic is_leap(logic [1:0] ylo, logic [6:0] rem, logic [6:0] cent);
    return ((ylo == 2'd0) && (rem != 7'd0)) || ((rem == 7'd0) && (cent[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: sv/gregorian_date_offset_weekday.sv
// Top level of the Gregorian date shifter with weekday and date order.
//
// Usage: present a request on req_i and raise start_i; the transfer is taken at
// the rising edge where start_i is high and busy_o is low. busy_o then stays
// high until the result has been shown. The result appears on res_o for exactly
// one cycle, marked by valid_o; the receiver cannot stall and must take it then.
// res_o carries the shifted date, the weekday of the base date (0 is Sunday),
// the order of base against the other date, and an overflow flag; on overflow
// the date fields echo the saturated base date.
// The sequencer steps through saturation, division, split, clamp, the offset
// walk (one step per month that the walk crosses, on the shared add/compare
// unit), the weekday sum (one step per month of the base year up to the base
// month) and the modulo; backward shifts that stay in range add a final step.
// At the offset limits the walk crosses about 1077 months.
// busy_o falls in the cycle after the strobe, where a new request can be taken.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle; no result is
// pending afterwards.
`include "gregorian_date_offset_weekday_macros.svh"

module gregorian_date_offset_weekday (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  gdow_pkg::gdow_req_t req_i,
  output logic                valid_o,
  output gdow_pkg::gdow_res_t res_o
);

  gdow_pkg::gdow_ctrl_t ctrl;
  gdow_pkg::gdow_stat_t stat;

  gdow_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy_o)
  );

  gdow_dp u_dp (
    .clk_i (clk_i),
    .req_i (req_i),
    .ctrl_i(ctrl),
    .stat_o(stat),
    .res_o (res_o)
  );

  assign valid_o = ctrl.done;

  `GDOW_ASSERT_IMPL(a_valid_busy, valid_o, busy_o, "result strobe outside a transfer")
  `GDOW_ASSERT_NEXT(a_valid_pulse, valid_o, !valid_o, "result strobe longer than one cycle")
  `GDOW_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o, "accepted transfer not busy")
  `GDOW_ASSERT_IMPL(a_month_rng, valid_o,
                    (res_o.month_out >= 4'd1) && (res_o.month_out <= 4'd12),
                    "month out of range")
  `GDOW_ASSERT_IMPL(a_day_wk_rng, valid_o,
                    (res_o.day_out != 5'd0) && (res_o.weekday <= 3'd6),
                    "day or weekday out of range")

endmodule

FILE: sv/gdow_alu.sv
// Shared add/subtract and compare unit of the date shifter.
module gdow_alu (
  input  gdow_pkg::gdow_alu_req_t req_i,
  output gdow_pkg::gdow_alu_rsp_t rsp_o
);

  logic signed [17:0] res;

  assign res       = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);
  assign rsp_o.res = res;
  assign rsp_o.pos = (res > 18'sd0);
  assign rsp_o.ge  = (req_i.a >= req_i.cmp);

endmodule

FILE: sv/gdow_seq.sv
// Sequencer that steps the shared datapath through one date transfer.
module gdow_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  gdow_pkg::gdow_stat_t stat_i,
  output gdow_pkg::gdow_ctrl_t ctrl_o,
  output logic                 busy_o
);

  gdow_pkg::gdow_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdow_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o.op   = gdow_pkg::OP_NONE;
    ctrl_o.done = 1'b0;
    busy_o      = (state_q != gdow_pkg::ST_IDLE);
    case (state_q)
      gdow_pkg::ST_IDLE: begin
        if (start_i) begin
          ctrl_o.op = gdow_pkg::OP_LOAD;
          state_d   = gdow_pkg::ST_SAT;
        end
      end
      gdow_pkg::ST_SAT: begin
        ctrl_o.op = gdow_pkg::OP_SAT;
        state_d   = gdow_pkg::ST_DIV;
      end
      gdow_pkg::ST_DIV: begin
        ctrl_o.op = gdow_pkg::OP_DIV;
        state_d   = gdow_pkg::ST_SPLIT;
      end
      gdow_pkg::ST_SPLIT: begin
        ctrl_o.op = gdow_pkg::OP_SPLIT;
        state_d   = gdow_pkg::ST_CLAMP;
      end
      gdow_pkg::ST_CLAMP: begin
        ctrl_o.op = gdow_pkg::OP_CLAMP;
        state_d   = gdow_pkg::ST_INITK;
      end
      gdow_pkg::ST_INITK: begin
        ctrl_o.op = gdow_pkg::OP_INITK;
        state_d   = stat_i.fwd ? gdow_pkg::ST_WALKF : gdow_pkg::ST_WALKB;
      end
      gdow_pkg::ST_WALKF: begin
        ctrl_o.op = gdow_pkg::OP_WALKF;
        if (stat_i.walk_flag || !stat_i.walk_cont) begin
          state_d = gdow_pkg::ST_WKINIT;
        end
      end
      gdow_pkg::ST_WALKB: begin
        ctrl_o.op = gdow_pkg::OP_WALKB;
        if (stat_i.walk_flag) begin
          state_d = gdow_pkg::ST_WKINIT;
        end else if (!stat_i.walk_cont) begin
          state_d = gdow_pkg::ST_FINB;
        end
      end
      gdow_pkg::ST_FINB: begin
        ctrl_o.op = gdow_pkg::OP_FINB;
        state_d   = gdow_pkg::ST_WKINIT;
      end
      gdow_pkg::ST_WKINIT: begin
        ctrl_o.op = gdow_pkg::OP_WKINIT;
        state_d   = gdow_pkg::ST_WKCENT;
      end
      gdow_pkg::ST_WKCENT: begin
        ctrl_o.op = gdow_pkg::OP_WKCENT;
        state_d   = gdow_pkg::ST_WKCENT4;
      end
      gdow_pkg::ST_WKCENT4: begin
        ctrl_o.op = gdow_pkg::OP_WKCENT4;
        state_d   = gdow_pkg::ST_WKMON;
      end
      gdow_pkg::ST_WKMON: begin
        ctrl_o.op = gdow_pkg::OP_WKMON;
        if (!stat_i.mon_cont) begin
          state_d = gdow_pkg::ST_WKDAY;
        end
      end
      gdow_pkg::ST_WKDAY: begin
        ctrl_o.op = gdow_pkg::OP_WKDAY;
        state_d   = gdow_pkg::ST_MODMUL;
      end
      gdow_pkg::ST_MODMUL: begin
        ctrl_o.op = gdow_pkg::OP_MODMUL;
        state_d   = gdow_pkg::ST_MODSUB;
      end
      gdow_pkg::ST_MODSUB: begin
        ctrl_o.op = gdow_pkg::OP_MODSUB;
        state_d   = gdow_pkg::ST_DONE;
      end
      gdow_pkg::ST_DONE: begin
        ctrl_o.done = 1'b1;
        state_d     = gdow_pkg::ST_IDLE;
      end
      default: begin
        state_d = gdow_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/gdow_dp.sv
// Datapath of the date shifter: operand registers, shared ALU and reciprocal multiplier.
module gdow_dp (
  input  logic                 clk_i,
  input  gdow_pkg::gdow_req_t  req_i,
  input  gdow_pkg::gdow_ctrl_t ctrl_i,
  output gdow_pkg::gdow_stat_t stat_o,
  output gdow_pkg::gdow_res_t  res_o
);

  gdow_pkg::gdow_req_t in_q;
  logic [1:0]          ord_q;
  logic [13:0]         y_q, ny_q;
  logic [3:0]          m_q, nm_q, mcnt_q;
  logic [4:0]          d_q, nd_q;
  logic [6:0]          yc_q, yr_q, nc_q, nr_q;
  logic signed [17:0]  k_q, acc_q;
  logic                flag_q;
  logic [2:0]          w_q;
  logic [gdow_pkg::PROD_W-1:0] prod_q;

  gdow_pkg::gdow_alu_req_t alu_req;
  gdow_pkg::gdow_alu_rsp_t alu_rsp;

  logic        leap_y, leap_n;
  logic [6:0]  cent_w, cprev;
  logic [13:0] hund, ym1, sev;
  logic [11:0] q7;
  logic [3:0]  pm;
  logic [4:0]  dim_f, dim_b, ml, dclamp;
  logic [22:0] key_a, key_b;
  logic signed [17:0] off_ext;

  gdow_alu u_alu (
    .req_i(alu_req),
    .rsp_o(alu_rsp)
  );

  assign leap_y  = gdow_pkg::is_leap(y_q[1:0], yr_q, yc_q);
  assign leap_n  = gdow_pkg::is_leap(ny_q[1:0], nr_q, nc_q);
  assign cent_w  = prod_q[gdow_pkg::SHIFT100 +: 7];
  assign hund    = {7'b0, cent_w} * gdow_pkg::YEAR_CENT;
  assign ym1     = y_q - 14'd1;
  assign cprev   = (yr_q == 7'd0) ? (yc_q - 7'd1) : yc_q;
  assign q7      = prod_q[gdow_pkg::SHIFT7 +: 12];
  assign sev     = {2'b0, q7} * gdow_pkg::WEEK_DAYS;
  assign pm      = (nm_q == 4'd1) ? gdow_pkg::MONTH_MAX : (nm_q - 4'd1);
  assign dim_f   = gdow_pkg::month_len(nm_q, leap_n);
  // A step back into February never crosses a year, so the current year's leap bit holds
  assign dim_b   = gdow_pkg::month_len(pm, leap_n);
  assign ml      = gdow_pkg::month_len(m_q, leap_y);
  assign dclamp  = (in_q.day_in == 5'd0) ? 5'd1 : ((in_q.day_in > ml) ? ml : in_q.day_in);
  assign off_ext = {{2{in_q.day_offset[15]}}, in_q.day_offset};
  assign key_a   = {req_i.year_in, req_i.month_in, req_i.day_in};
  assign key_b   = {req_i.other_year, req_i.other_month, req_i.other_day};

  // Operand select for the shared unit
  always_comb begin
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.cmp = '0;
    alu_req.sub = 1'b0;
    case (ctrl_i.op)
      gdow_pkg::OP_SPLIT: begin
        alu_req.a   = {4'b0, y_q};
        alu_req.b   = {4'b0, hund};
        alu_req.sub = 1'b1;
      end
      gdow_pkg::OP_INITK: begin
        if (!in_q.day_offset[15]) begin
          alu_req.a = off_ext;
          alu_req.b = {13'b0, d_q};
        end else begin
          alu_req.b   = off_ext;
          alu_req.sub = 1'b1;
        end
      end
      gdow_pkg::OP_WALKF: begin
        alu_req.a   = k_q;
        alu_req.b   = {13'b0, dim_f};
        alu_req.sub = 1'b1;
      end
      gdow_pkg::OP_WALKB: begin
        alu_req.a   = k_q;
        alu_req.b   = {13'b0, dim_b};
        alu_req.cmp = {13'b0, nd_q};
        alu_req.sub = 1'b1;
      end
      gdow_pkg::OP_FINB: begin
        alu_req.a   = {13'b0, nd_q};
        alu_req.b   = k_q;
        alu_req.sub = 1'b1;
      end
      gdow_pkg::OP_WKINIT: begin
        alu_req.a = {4'b0, ym1};
        alu_req.b = {6'b0, ym1[13:2]};
      end
      gdow_pkg::OP_WKCENT: begin
        alu_req.a   = acc_q;
        alu_req.b   = {11'b0, cprev};
        alu_req.sub = 1'b1;
      end
      gdow_pkg::OP_WKCENT4: begin
        alu_req.a = acc_q;
        alu_req.b = {13'b0, cprev[6:2]};
      end
      gdow_pkg::OP_WKMON: begin
        alu_req.a = acc_q;
        alu_req.b = {13'b0, gdow_pkg::month_len(mcnt_q, leap_y)};
      end
      gdow_pkg::OP_WKDAY: begin
        alu_req.a = acc_q;
        alu_req.b = {13'b0, d_q};
      end
      gdow_pkg::OP_MODSUB: begin
        alu_req.a   = acc_q;
        alu_req.b   = {4'b0, sev};
        alu_req.sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat_o.fwd = !in_q.day_offset[15];
    if (stat_o.fwd) begin
      stat_o.walk_cont = alu_rsp.pos;
      stat_o.walk_flag = alu_rsp.pos && (nm_q == gdow_pkg::MONTH_MAX) &&
                         (ny_q == gdow_pkg::YEAR_MAX);
    end else begin
      stat_o.walk_cont = alu_rsp.ge;
      stat_o.walk_flag = alu_rsp.ge && (nm_q == 4'd1) && (ny_q == 14'd1);
    end
    stat_o.mon_cont = (mcnt_q < m_q);
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      gdow_pkg::OP_LOAD: begin
        in_q <= req_i;
        if (key_a < key_b) begin
          ord_q <= gdow_pkg::ORD_EARLIER;
        end else if (key_a == key_b) begin
          ord_q <= gdow_pkg::ORD_EQUAL;
        end else begin
          ord_q <= gdow_pkg::ORD_LATER;
        end
      end
      gdow_pkg::OP_SAT: begin
        flag_q <= 1'b0;
        if (in_q.year_in == 14'd0) begin
          y_q <= 14'd1;
        end else if (in_q.year_in > gdow_pkg::YEAR_MAX) begin
          y_q <= gdow_pkg::YEAR_MAX;
        end else begin
          y_q <= in_q.year_in;
        end
        if (in_q.month_in == 4'd0) begin
          m_q <= 4'd1;
        end else if (in_q.month_in > gdow_pkg::MONTH_MAX) begin
          m_q <= gdow_pkg::MONTH_MAX;
        end else begin
          m_q <= in_q.month_in;
        end
      end
      gdow_pkg::OP_DIV: begin
        prod_q <= {15'b0, y_q} * gdow_pkg::PROD_W'(gdow_pkg::RECIP100);
      end
      gdow_pkg::OP_SPLIT: begin
        yc_q <= cent_w;
        yr_q <= alu_rsp.res[6:0];
        nc_q <= cent_w;
        nr_q <= alu_rsp.res[6:0];
        ny_q <= y_q;
        nm_q <= m_q;
      end
      gdow_pkg::OP_CLAMP: begin
        d_q  <= dclamp;
        nd_q <= dclamp;
      end
      gdow_pkg::OP_INITK: begin
        k_q <= alu_rsp.res;
      end
      gdow_pkg::OP_WALKF: begin
        if (alu_rsp.pos) begin
          k_q <= alu_rsp.res;
          if (nm_q == gdow_pkg::MONTH_MAX) begin
            nm_q <= 4'd1;
            if (ny_q == gdow_pkg::YEAR_MAX) begin
              flag_q <= 1'b1;
            end else begin
              ny_q <= ny_q + 14'd1;
              if (nr_q == gdow_pkg::CENT_LAST) begin
                nr_q <= 7'd0;
                nc_q <= nc_q + 7'd1;
              end else begin
                nr_q <= nr_q + 7'd1;
              end
            end
          end else begin
            nm_q <= nm_q + 4'd1;
          end
        end else begin
          nd_q <= k_q[4:0];
        end
      end
      gdow_pkg::OP_WALKB: begin
        if (alu_rsp.ge) begin
          k_q  <= alu_rsp.res;
          nm_q <= pm;
          if (nm_q == 4'd1) begin
            if (ny_q == 14'd1) begin
              flag_q <= 1'b1;
            end else begin
              ny_q <= ny_q - 14'd1;
              if (nr_q == 7'd0) begin
                nr_q <= gdow_pkg::CENT_LAST;
                nc_q <= nc_q - 7'd1;
              end else begin
                nr_q <= nr_q - 7'd1;
              end
            end
          end
        end
      end
      gdow_pkg::OP_FINB: begin
        nd_q <= alu_rsp.res[4:0];
      end
      gdow_pkg::OP_WKINIT: begin
        acc_q  <= alu_rsp.res;
        mcnt_q <= 4'd1;
      end
      gdow_pkg::OP_WKCENT, gdow_pkg::OP_WKCENT4, gdow_pkg::OP_WKDAY: begin
        acc_q <= alu_rsp.res;
      end
      gdow_pkg::OP_WKMON: begin
        if (mcnt_q < m_q) begin
          acc_q  <= alu_rsp.res;
          mcnt_q <= mcnt_q + 4'd1;
        end
      end
      gdow_pkg::OP_MODMUL: begin
        prod_q <= {15'b0, acc_q[13:0]} * gdow_pkg::PROD_W'(gdow_pkg::RECIP7);
      end
      gdow_pkg::OP_MODSUB: begin
        w_q <= alu_rsp.res[2:0];
      end
      default: begin
      end
    endcase
  end

  assign res_o.year_out     = flag_q ? y_q : ny_q;
  assign res_o.month_out    = flag_q ? m_q : nm_q;
  assign res_o.day_out      = flag_q ? d_q : nd_q;
  assign res_o.weekday      = w_q;
  assign res_o.order        = ord_q;
  assign res_o.out_of_range = flag_q;

endmodule
